@@ src/sce_pkg.sv @@
// Shared types, constants and helper functions for the knot-point cost evaluator.
`default_nettype none

package sce_pkg;

  localparam int unsigned TIME_STEP_DEF = 6554;
  localparam int unsigned BASE_COST_DEF = 65536;

  localparam logic signed [20:0] PI_Q16      = 21'sd205887;
  localparam logic signed [20:0] TWO_PI_Q16  = 21'sd411775;
  localparam logic signed [20:0] HALF_PI_Q16 = 21'sd102944;

  localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;
  localparam int unsigned CORDIC_STEPS = 16;

  // floor(|h| / 2pi) estimate: drop low bits, multiply by a scaled reciprocal
  localparam int unsigned REDUCE_DROP  = 13;
  localparam int unsigned REDUCE_SHIFT = 24;
  localparam logic [18:0] REDUCE_RECIP = 19'd333770;

  // pipeline depths: reduction, trig products / step scaling, cost; delay that aligns the cost path
  localparam int unsigned REDUCE_DEPTH = 5;
  localparam int unsigned DYN_DEPTH    = 4;
  localparam int unsigned COST_DEPTH   = 7;
  localparam int unsigned COST_DELAY   = REDUCE_DEPTH + CORDIC_STEPS + DYN_DEPTH - COST_DEPTH;

  localparam logic [47:0] COST_MAX = 48'hFFFF_FFFF_FFFF;

  localparam int unsigned IN_W  = 288;
  localparam int unsigned OUT_W = 400;

  localparam logic [23:0] RST_W_CTRL_ONE   = 24'd78643;
  localparam logic [23:0] RST_W_CTRL_TWO   = 24'd111411;
  localparam logic [23:0] RST_W_CTRL_THREE = 24'd45875;
  localparam logic [23:0] RST_W_POSITION   = 24'd65536;
  localparam logic [23:0] RST_W_HEADING    = 24'd65536;

  typedef enum logic [2:0] {
    CFG_W_CTRL_ONE   = 3'd0,
    CFG_W_CTRL_TWO   = 3'd1,
    CFG_W_CTRL_THREE = 3'd2,
    CFG_W_POSITION   = 3'd3,
    CFG_W_HEADING    = 3'd4,
    CFG_TARGET_X     = 3'd5,
    CFG_TARGET_Y     = 3'd6,
    CFG_TARGET_HEAD  = 3'd7
  } cfg_idx_t;

  // last field in the lowest bits
  typedef struct packed {
    logic signed [31:0] ctrl_three;
    logic signed [31:0] ctrl_two;
    logic signed [31:0] ctrl_one;
    logic signed [31:0] speed_other;
    logic signed [31:0] speed_turn;
    logic signed [31:0] speed_forward;
    logic signed [31:0] heading;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_x;
  } item_t;

  typedef struct packed {
    logic signed [31:0] jac_y_heading;
    logic signed [31:0] jac_x_heading;
    logic signed [31:0] grad_heading;
    logic signed [31:0] grad_y;
    logic signed [31:0] grad_x;
    logic        [47:0] cost_value;
    logic signed [31:0] next_other;
    logic signed [31:0] next_turn;
    logic signed [31:0] next_forward;
    logic signed [31:0] next_heading;
    logic signed [31:0] next_y;
    logic signed [31:0] next_x;
  } res_t;

  typedef struct packed {
    logic        [23:0] w_ctrl_one;
    logic        [23:0] w_ctrl_two;
    logic        [23:0] w_ctrl_three;
    logic        [23:0] w_position;
    logic        [23:0] w_heading;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [18:0] target_head;
  } cfg_t;

  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [19:0] z;
    logic               flip;
  } rot_t;

  typedef struct packed {
    logic        [47:0] cost;
    logic signed [31:0] gx;
    logic signed [31:0] gy;
    logic signed [31:0] gh;
  } cost_res_t;

  function automatic logic signed [19:0] atan_q16(input int unsigned idx);
    logic signed [19:0] a;
    unique case (idx)
      0:       a = 20'sd51472;
      1:       a = 20'sd30386;
      2:       a = 20'sd16055;
      3:       a = 20'sd8150;
      4:       a = 20'sd4091;
      5:       a = 20'sd2047;
      6:       a = 20'sd1024;
      7:       a = 20'sd512;
      8:       a = 20'sd256;
      9:       a = 20'sd128;
      10:      a = 20'sd64;
      11:      a = 20'sd32;
      12:      a = 20'sd16;
      13:      a = 20'sd8;
      14:      a = 20'sd4;
      default: a = 20'sd2;
    endcase
    return a;
  endfunction

  function automatic logic signed [31:0] sat_s32(input logic signed [59:0] v);
    logic signed [31:0] r;
    if (v > 60'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -60'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/unicycle_step_cost_eval_top.sv @@
// Top level: knot-point evaluator with angle reduction, rotation cell chain, cost and output skid.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in_     | slave     | in_tvalid/in_tready  | in_tdata, 288 bits: nine Q16.16 fields
//  out_    | master    | out_tvalid/out_tready| out_tdata, 400 bits: next state, cost, grads
//  cfg_    | slave     | cfg_valid/cfg_ready  | cfg_index 3 bits, cfg_data 32 bits
//
// One knot point per clock cycle while the skid register is empty; an input transfer passes
// the input register, five reduction stages, sixteen rotation cells and four product/step
// stages to the output register that drives out_tvalid. The sixteen-cell rotation chain sets
// the depth. Reset clears valid bits and the skid flag and presets the configuration registers.
// When the output stalls, one finished result parks in a skid register; while it is full the
// whole pipeline holds and in_tready is low. cfg_ready is always high.
`default_nettype none

module unicycle_step_cost_eval_top import sce_pkg::*; #(
  parameter int unsigned TIME_STEP_Q16 = TIME_STEP_DEF,
  parameter int unsigned BASE_COST_Q16 = BASE_COST_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // pos_x, pos_y, heading, speed_forward, speed_turn, speed_other,
  // ctrl_one, ctrl_two, ctrl_three (32 bits each, lowest first)
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // next_x, next_y, next_heading, next_forward, next_turn, next_other (32 each),
  // cost_value (48), grad_x, grad_y, grad_heading, jac_x_heading, jac_y_heading (32 each)
  output logic [OUT_W-1:0] out_tdata,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data
);

  localparam logic signed [17:0] STEP_S = 18'(TIME_STEP_Q16);

  logic adv;        // whole pipeline advances
  cfg_t cfg_r;

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.w_ctrl_one   <= RST_W_CTRL_ONE;
      cfg_r.w_ctrl_two   <= RST_W_CTRL_TWO;
      cfg_r.w_ctrl_three <= RST_W_CTRL_THREE;
      cfg_r.w_position   <= RST_W_POSITION;
      cfg_r.w_heading    <= RST_W_HEADING;
      cfg_r.target_x     <= '0;
      cfg_r.target_y     <= '0;
      cfg_r.target_head  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_W_CTRL_ONE:   cfg_r.w_ctrl_one   <= cfg_data[23:0];
        CFG_W_CTRL_TWO:   cfg_r.w_ctrl_two   <= cfg_data[23:0];
        CFG_W_CTRL_THREE: cfg_r.w_ctrl_three <= cfg_data[23:0];
        CFG_W_POSITION:   cfg_r.w_position   <= cfg_data[23:0];
        CFG_W_HEADING:    cfg_r.w_heading    <= cfg_data[23:0];
        CFG_TARGET_X:     cfg_r.target_x     <= cfg_data;
        CFG_TARGET_Y:     cfg_r.target_y     <= cfg_data;
        CFG_TARGET_HEAD:  cfg_r.target_head  <= cfg_data[18:0];
      endcase
    end
  end

  // ---------------- input register ----------------
  logic  v0_r;
  item_t item0_r;

  // ---------------- angle reduction ----------------
  logic        v1_r, v2_r, v3_r, v4_r, v5_r;
  item_t       item1_r, item2_r, item3_r, item4_r, item5_r;
  logic [31:0] habs1_r, habs2_r;
  logic        neg1_r, neg2_r, neg3_r;
  logic [12:0] q2_r;
  logic [19:0] r3_r;
  logic signed [19:0] rs4_r;
  rot_t        rot5_r;

  logic [32:0]        h_ext;
  logic [37:0]        q_prod;
  logic [19:0]        r_corr;
  logic signed [19:0] r_mag;
  logic signed [20:0] r_shift;
  logic signed [20:0] r_fold;
  logic               fold;

  always_comb begin
    h_ext   = {item0_r.heading[31], item0_r.heading};
    q_prod  = 38'(habs1_r[31:REDUCE_DROP]) * 38'(REDUCE_RECIP);
    r_corr  = (r3_r >= 20'(TWO_PI_Q16)) ? r3_r - 20'(TWO_PI_Q16) : r3_r;
    r_mag   = $signed({1'b0, r_corr[18:0]});
    // one shift by 2pi into [-pi, pi], then fold by pi into [-pi/2, pi/2]
    if (21'(rs4_r) > PI_Q16) r_shift = 21'(rs4_r) - TWO_PI_Q16;
    else if (21'(rs4_r) < -PI_Q16) r_shift = 21'(rs4_r) + TWO_PI_Q16;
    else r_shift = 21'(rs4_r);
    if (r_shift > HALF_PI_Q16) begin
      r_fold = r_shift - PI_Q16;
      fold   = 1'b1;
    end else if (r_shift < -HALF_PI_Q16) begin
      r_fold = r_shift + PI_Q16;
      fold   = 1'b1;
    end else begin
      r_fold = r_shift;
      fold   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_tvalid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item0_r <= item_t'(in_tdata);
      // stage 1: magnitude and sign of the heading
      item1_r <= item0_r;
      neg1_r  <= item0_r.heading[31];
      habs1_r <= item0_r.heading[31] ? 32'(-h_ext) : 32'(h_ext);
      // stage 2: quotient estimate, low by at most one
      item2_r <= item1_r;
      neg2_r  <= neg1_r;
      habs2_r <= habs1_r;
      q2_r    <= 13'(q_prod >> REDUCE_SHIFT);
      // stage 3: remainder before correction
      item3_r <= item2_r;
      neg3_r  <= neg2_r;
      r3_r    <= 20'(habs2_r - 32'(q2_r) * 32'(TWO_PI_Q16));
      // stage 4: correct and restore the sign of the truncated remainder
      item4_r <= item3_r;
      rs4_r   <= neg3_r ? -r_mag : r_mag;
      // stage 5: shift, fold, load the rotation vector
      item5_r     <= item4_r;
      rot5_r.x    <= CORDIC_GAIN_Q30;
      rot5_r.y    <= '0;
      rot5_r.z    <= 20'(r_fold);
      rot5_r.flip <= fold;
    end
  end

  // ---------------- rotation cell chain ----------------
  logic  ch_vld  [CORDIC_STEPS+1];
  rot_t  ch_rot  [CORDIC_STEPS+1];
  item_t ch_item [CORDIC_STEPS+1];

  assign ch_vld[0]  = v5_r;
  assign ch_rot[0]  = rot5_r;
  assign ch_item[0] = item5_r;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    sce_cordic_cell #(.STEP(g)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .in_vld   (ch_vld[g]),
      .in_rot   (ch_rot[g]),
      .in_item  (ch_item[g]),
      .out_vld  (ch_vld[g+1]),
      .out_rot  (ch_rot[g+1]),
      .out_item (ch_item[g+1])
    );
  end

  // ---------------- trig products and step scaling ----------------
  logic               k1_v_r, k2_v_r, k3_v_r, k4_v_r;
  item_t              k1_item_r, k2_item_r, k3_item_r, k4_item_r;
  logic signed [19:0] c1_r, s1_r;
  logic signed [51:0] pcf2_r, pst2_r, pco2_r, psf2_r, pct2_r;
  logic signed [31:0] hs2_r, fs2_r, ts2_r, os2_r;
  logic signed [31:0] hs3_r, fs3_r, ts3_r, os3_r;
  logic signed [31:0] hs4_r, fs4_r, ts4_r, os4_r;
  logic signed [36:0] sa3_r, sb3_r, sj3_r;
  logic signed [38:0] ta4_r, tb4_r, tj4_r;

  rot_t               rot_end;
  logic signed [32:0] xr, yr;
  logic signed [18:0] cr, sr;
  logic signed [49:0] ph, pf, pt, po;

  always_comb begin
    rot_end = ch_rot[CORDIC_STEPS];
    xr = rot_end.x + 33'sd8192;
    yr = rot_end.y + 33'sd8192;
    cr = 19'(xr >>> 14);
    sr = 19'(yr >>> 14);
    ph = 50'(k1_item_r.speed_other) * 50'(STEP_S);
    pf = 50'(k1_item_r.ctrl_one)    * 50'(STEP_S);
    pt = 50'(k1_item_r.ctrl_two)    * 50'(STEP_S);
    po = 50'(k1_item_r.ctrl_three)  * 50'(STEP_S);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k1_v_r <= 1'b0;
      k2_v_r <= 1'b0;
      k3_v_r <= 1'b0;
      k4_v_r <= 1'b0;
    end else if (adv) begin
      k1_v_r <= ch_vld[CORDIC_STEPS];
      k2_v_r <= k1_v_r;
      k3_v_r <= k2_v_r;
      k4_v_r <= k3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // round to Q16.16, undo the fold
      k1_item_r <= ch_item[CORDIC_STEPS];
      c1_r <= rot_end.flip ? -20'(cr) : 20'(cr);
      s1_r <= rot_end.flip ? -20'(sr) : 20'(sr);

      k2_item_r <= k1_item_r;
      pcf2_r <= 52'(c1_r) * 52'(k1_item_r.speed_forward);
      pst2_r <= 52'(s1_r) * 52'(k1_item_r.speed_turn);
      pco2_r <= 52'(c1_r) * 52'(k1_item_r.speed_other);
      psf2_r <= 52'(s1_r) * 52'(k1_item_r.speed_forward);
      pct2_r <= 52'(c1_r) * 52'(k1_item_r.speed_turn);
      hs2_r  <= ph[47:16];
      fs2_r  <= pf[47:16];
      ts2_r  <= pt[47:16];
      os2_r  <= po[47:16];

      k3_item_r <= k2_item_r;
      sa3_r <= 37'((53'(pcf2_r) - 53'(pst2_r)) >>> 16);
      sb3_r <= 37'((53'(pco2_r) + 53'(pst2_r)) >>> 16);
      sj3_r <= 37'((-53'(psf2_r) - 53'(pct2_r)) >>> 16);
      hs3_r <= hs2_r;
      fs3_r <= fs2_r;
      ts3_r <= ts2_r;
      os3_r <= os2_r;

      k4_item_r <= k3_item_r;
      ta4_r <= 39'((55'(sa3_r) * 55'(STEP_S)) >>> 16);
      tb4_r <= 39'((55'(sb3_r) * 55'(STEP_S)) >>> 16);
      tj4_r <= 39'((55'(sj3_r) * 55'(STEP_S)) >>> 16);
      hs4_r <= hs3_r;
      fs4_r <= fs3_r;
      ts4_r <= ts3_r;
      os4_r <= os3_r;
    end
  end

  // ---------------- cost and gradients ----------------
  cost_res_t cost_res;

  sce_cost #(.BASE_COST_Q16(BASE_COST_Q16)) u_cost (
    .clk  (clk),
    .en   (adv),
    .item (item0_r),
    .cfg  (cfg_r),
    .res  (cost_res)
  );

  // ---------------- result assembly ----------------
  res_t res_nxt;

  always_comb begin
    res_nxt.next_x        = k4_item_r.pos_x + ta4_r[31:0];
    res_nxt.next_y        = k4_item_r.pos_y + tb4_r[31:0];
    res_nxt.next_heading  = k4_item_r.heading + hs4_r;
    res_nxt.next_forward  = k4_item_r.speed_forward + fs4_r;
    res_nxt.next_turn     = k4_item_r.speed_turn + ts4_r;
    res_nxt.next_other    = k4_item_r.speed_other + os4_r;
    res_nxt.cost_value    = cost_res.cost;
    res_nxt.grad_x        = cost_res.gx;
    res_nxt.grad_y        = cost_res.gy;
    res_nxt.grad_heading  = cost_res.gh;
    res_nxt.jac_x_heading = sat_s32(60'(tj4_r));
    res_nxt.jac_y_heading = sat_s32(60'(ta4_r));
  end

  // ---------------- output register and skid ----------------
  logic out_vld_r;
  logic skid_full_r;
  res_t out_r;
  res_t skid_r;

  assign adv       = !skid_full_r;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r   <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (adv) begin
      if (out_vld_r && !out_tready) begin
        // output stalled: park a new result
        skid_full_r <= k4_v_r;
      end else begin
        out_vld_r <= k4_v_r;
      end
    end else if (out_tready) begin
      // drain the parked result
      out_vld_r   <= 1'b1;
      skid_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (out_vld_r && !out_tready) begin
        skid_r <= res_nxt;
      end else begin
        out_r <= res_nxt;
      end
    end else if (out_tready) begin
      out_r <= skid_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r;

  // ---------------- assertions ----------------
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |-> out_vld_r)
    else $error("skid holds a result while the output register is empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r && !out_tready |=> skid_full_r)
    else $error("parked result dropped while output stalled");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_vld_r && !skid_full_r)
    else $error("output valid or skid set after reset");

  a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r |-> (21'(rot5_r.z) <= HALF_PI_Q16) && (21'(rot5_r.z) >= -HALF_PI_Q16))
    else $error("reduced angle outside plus or minus half pi");

  a_cost_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> out_r.cost_value >= 48'(BASE_COST_Q16))
    else $error("cost below base cost");

endmodule

`default_nettype wire

@@ src/sce_cordic_cell.sv @@
// One rotation cell of the sine/cosine chain: one CORDIC iteration and one register stage.
`default_nettype none

module sce_cordic_cell import sce_pkg::*; #(
  parameter int unsigned STEP = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_vld,
  input  rot_t  in_rot,
  input  item_t in_item,
  output logic  out_vld,
  output rot_t  out_rot,
  output item_t out_item
);

  logic               vld_r;
  rot_t               rot_r;
  item_t              item_r;
  rot_t               rot_nxt;
  logic signed [32:0] sx;
  logic signed [32:0] sy;
  logic signed [19:0] ang;

  always_comb begin
    sx  = in_rot.y >>> STEP;
    sy  = in_rot.x >>> STEP;
    ang = atan_q16(STEP);
    rot_nxt.flip = in_rot.flip;
    if (!in_rot.z[19]) begin
      rot_nxt.x = in_rot.x - sx;
      rot_nxt.y = in_rot.y + sy;
      rot_nxt.z = in_rot.z - ang;
    end else begin
      rot_nxt.x = in_rot.x + sx;
      rot_nxt.y = in_rot.y - sy;
      rot_nxt.z = in_rot.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_r  <= rot_nxt;
      item_r <= in_item;
    end
  end

  assign out_vld  = vld_r;
  assign out_rot  = rot_r;
  assign out_item = item_r;

endmodule

`default_nettype wire

@@ src/sce_cost.sv @@
// Cost and gradient pipeline with a trailing delay line to line up with the dynamics path.
`default_nettype none

module sce_cost import sce_pkg::*; #(
  parameter int unsigned BASE_COST_Q16 = BASE_COST_DEF
) (
  input  logic      clk,
  input  logic      en,
  input  item_t     item,
  input  cfg_t      cfg,
  output cost_res_t res
);

  localparam logic [59:0] BASE = 60'(BASE_COST_Q16);

  function automatic logic [31:0] mag32(input logic signed [33:0] v);
    logic signed [33:0] n;
    n = -v;
    return v[33] ? n[31:0] : v[31:0];
  endfunction

  // stage 1: errors to target
  logic signed [32:0] dx1_r, dy1_r, dth1_r;
  logic signed [31:0] u1_r [3];
  // stage 2: heading wrap, magnitudes
  logic signed [33:0] dx2_r, dy2_r, dth2_r;
  logic        [31:0] m2_r [6];
  logic signed [33:0] dthw;
  // stage 3: squares, gradient products
  logic        [63:0] sq3_r [6];
  logic signed [58:0] gp3_r [3];
  // stage 4: weight times square halves, gradients
  logic        [55:0] whi4_r [6];
  logic        [55:0] wlo4_r [6];
  logic signed [31:0] g4_r [3];
  logic signed [31:0] g5_r [3];
  logic signed [31:0] g6_r [3];
  // stage 5..7: terms, pair sums, total
  logic        [56:0] t5_r [6];
  logic        [57:0] p6_r [3];
  cost_res_t          c7_r;
  logic        [59:0] tot;
  logic        [23:0] w [6];
  cost_res_t          dly_r [COST_DELAY];

  assign w[0] = cfg.w_ctrl_one;
  assign w[1] = cfg.w_ctrl_two;
  assign w[2] = cfg.w_ctrl_three;
  assign w[3] = cfg.w_position;
  assign w[4] = cfg.w_position;
  assign w[5] = cfg.w_heading;

  always_comb begin
    if (34'(dth1_r) > 34'(PI_Q16)) dthw = 34'(dth1_r) - 34'(TWO_PI_Q16);
    else if (34'(dth1_r) < -34'(PI_Q16)) dthw = 34'(dth1_r) + 34'(TWO_PI_Q16);
    else dthw = 34'(dth1_r);
  end

  always_comb begin
    tot = BASE + 60'(p6_r[0]) + 60'(p6_r[1]) + 60'(p6_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1_r  <= 33'(cfg.target_x) - 33'(item.pos_x);
      dy1_r  <= 33'(cfg.target_y) - 33'(item.pos_y);
      dth1_r <= 33'(cfg.target_head) - 33'(item.heading);
      u1_r[0] <= item.ctrl_one;
      u1_r[1] <= item.ctrl_two;
      u1_r[2] <= item.ctrl_three;

      dx2_r  <= 34'(dx1_r);
      dy2_r  <= 34'(dy1_r);
      dth2_r <= dthw;
      m2_r[0] <= mag32(34'(u1_r[0]));
      m2_r[1] <= mag32(34'(u1_r[1]));
      m2_r[2] <= mag32(34'(u1_r[2]));
      m2_r[3] <= mag32(34'(dx1_r));
      m2_r[4] <= mag32(34'(dy1_r));
      m2_r[5] <= mag32(dthw);

      for (int i = 0; i < 6; i++) begin
        sq3_r[i]  <= 64'(m2_r[i]) * 64'(m2_r[i]);
        whi4_r[i] <= 56'(w[i]) * 56'(sq3_r[i][63:32]);
        wlo4_r[i] <= 56'(w[i]) * 56'(sq3_r[i][31:0]);
        t5_r[i]   <= 57'(whi4_r[i]) + 57'(wlo4_r[i][55:32]);
      end
      gp3_r[0] <= 59'($signed({1'b0, cfg.w_position})) * 59'(dx2_r);
      gp3_r[1] <= 59'($signed({1'b0, cfg.w_position})) * 59'(dy2_r);
      gp3_r[2] <= 59'($signed({1'b0, cfg.w_heading})) * 59'(dth2_r);

      for (int k = 0; k < 3; k++) begin
        g4_r[k] <= sat_s32((-60'(gp3_r[k])) >>> 15);
        g5_r[k] <= g4_r[k];
        g6_r[k] <= g5_r[k];
      end

      p6_r[0] <= 58'(t5_r[0]) + 58'(t5_r[1]);
      p6_r[1] <= 58'(t5_r[2]) + 58'(t5_r[3]);
      p6_r[2] <= 58'(t5_r[4]) + 58'(t5_r[5]);

      c7_r.cost <= (tot > 60'(COST_MAX)) ? COST_MAX : tot[47:0];
      c7_r.gx   <= g6_r[0];
      c7_r.gy   <= g6_r[1];
      c7_r.gh   <= g6_r[2];

      dly_r[0] <= c7_r;
      for (int d = 1; d < COST_DELAY; d++) begin
        dly_r[d] <= dly_r[d-1];
      end
    end
  end

  assign res = dly_r[COST_DELAY-1];

endmodule

`default_nettype wire
